// File: rtl/pcsc_pkg.sv
`timescale 1ns / 1ps

package pcsc_pkg;

    // Grid limits and store geometry
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int STORE_AW       = 16;
    localparam int STORE_DEPTH    = 2 ** STORE_AW;

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_PATH   = 2'd2;

    // Verdict codes
    localparam logic [2:0] REASON_SAFE     = 3'd0;
    localparam logic [2:0] REASON_DISABLED = 3'd1;
    localparam logic [2:0] REASON_NO_MAP   = 3'd2;
    localparam logic [2:0] REASON_OUT      = 3'd3;
    localparam logic [2:0] REASON_UNKNOWN  = 3'd4;
    localparam logic [2:0] REASON_HIGH     = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_UNKNOWN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_M   = 3'd7;

    // Configuration reset values
    localparam logic [7:0]  THRESHOLD_RST = 8'd253;
    localparam logic [8:0]  MAP_DIM_RST   = 9'd256;
    localparam logic [31:0] CPM_RST       = 32'd1310720;

    // Cost codes
    localparam logic [7:0] COST_UNKNOWN = 8'd255;
    localparam logic [7:0] COST_LETHAL  = 8'd254;

    // Occupancy scaling: cost = (occ*252 + 25) / 50, done by reciprocal
    localparam int OCC_FULL  = 50;
    localparam int OCC_SCALE = 252;
    localparam int OCC_HALF  = OCC_FULL / 2;
    localparam int OCC_SHIFT = 20;
    localparam int OCC_RECIP = (2 ** OCC_SHIFT + OCC_FULL - 1) / OCC_FULL;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        cell_index;
        logic signed [7:0]  occupancy;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic [2:0] reason;
        logic       safe;
        logic [7:0] peak_cost;
    } t_out_word;

    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_mem_req;

    // Convert an occupancy percent into a cost byte
    function automatic logic [7:0] occ_to_cost(input logic signed [7:0] occ);
        logic [13:0] x;
        logic [28:0] p;
        begin
            x = 14'(occ) * 14'(OCC_SCALE) + 14'(OCC_HALF);
            p = {15'b0, x} * 29'(OCC_RECIP);
            if (occ[7]) begin
                occ_to_cost = COST_UNKNOWN;
            end else if (occ == 8'sd0) begin
                occ_to_cost = 8'd0;
            end else if (occ > 8'sd50) begin
                occ_to_cost = COST_LETHAL;
            end else begin
                occ_to_cost = p[OCC_SHIFT+7:OCC_SHIFT];
            end
        end
    endfunction

endpackage

// File: rtl/pcsc_cost_mem.sv
`timescale 1ns / 1ps

module pcsc_cost_mem (
    input  logic              i_clk,
    input  pcsc_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [pcsc_pkg::STORE_DEPTH];
    logic [7:0] r_rdata;

    // Write on request, read every cycle at the same address
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pcsc_mul.sv
`timescale 1ns / 1ps

module pcsc_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    // Register the full product
    always_ff @(posedge i_clk) begin
        r_prod <= {32'b0, i_a} * {32'b0, i_b};
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/path_costmap_safety_check.sv
`timescale 1ns / 1ps
// Cost grid store with a path safety checker.
// Input channel (i_in_valid / o_in_stall / i_in_word) carries load, commit and
// path pose words; a word is taken when valid is high and stall is low.
// Load and commit words stream at one per cycle while the sequencer is idle.
// A path pose runs through one shared 32x32 multiplier three times (column,
// row, row times width) and then one registered read of the cost memory; the
// input stalls until its work ends. A pose that finds its path already
// stopped, the check disabled or no committed map goes straight to the done
// state. A pose that lands off the grid stops after the range check.
// The pose marked last writes one result word into the output register from
// its done state; the output channel (o_out_valid / i_out_stall /
// o_out_word) holds that word while stalled, and the next pose may run
// meanwhile. A last pose whose result finds the register still occupied waits.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken.
// Reset restores default registers and clears the map-ready flag and path state;
// the cost memory is not cleared: the user must load every cell before use (not enforced).
module path_costmap_safety_check #(
    parameter int MAX_WIDTH  = pcsc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pcsc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pcsc_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pcsc_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
    localparam int HW_RAW = $clog2(MAX_HEIGHT + 1);
    localparam int WEW    = (WW_RAW > 9) ? WW_RAW : 9;
    localparam int HEW    = (HW_RAW > 9) ? HW_RAW : 9;

    typedef enum logic [2:0] {
        S_IDLE, S_MULX, S_MULY, S_RANGE, S_MULI, S_ADDR, S_EVAL, S_DONE
    } t_state;

    // Configuration registers
    logic               r_check_enable;
    logic               r_allow_unknown;
    logic [7:0]         r_threshold;
    logic [8:0]         r_map_width;
    logic [8:0]         r_map_height;
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_cpm;

    // Sequencer and path state
    t_state              r_state, n_state;
    logic signed [32:0]  r_dx, n_dx;
    logic signed [32:0]  r_dy, n_dy;
    logic [31:0]         r_col, n_col;
    logic [31:0]         r_row, n_row;
    logic                r_last, n_last;
    logic                r_map_ready, n_map_ready;
    logic                r_stopped, n_stopped;
    logic [2:0]          r_verdict, n_verdict;
    logic [7:0]          r_run_max, n_run_max;
    logic                r_out_valid, n_out_valid;
    pcsc_pkg::t_out_word r_out_word, n_out_word;

    logic                in_acc;
    logic                out_free;
    logic                emit;
    logic                off_map;
    logic [WEW-1:0]      w_eff;
    logic [HEW-1:0]      h_eff;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_prod;
    logic [31:0]         prod_hi;
    logic [7:0]          cost;
    pcsc_pkg::t_mem_req  mem_req;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign prod_hi     = mul_prod[63:32];

    // Saturate grid size to the build limits
    assign w_eff = (32'(r_map_width) > 32'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : WEW'(r_map_width);
    assign h_eff = (32'(r_map_height) > 32'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT)
                                                         : HEW'(r_map_height);

    // Row product is in prod_hi during the range check
    assign off_map = r_dx[32] || r_dy[32] || (r_col >= 32'(w_eff)) || (prod_hi >= 32'(h_eff));

    // Select shared multiplier operands
    always_comb begin
        case (r_state)
            S_MULX: begin
                mul_a = r_dx[31:0];
                mul_b = r_cpm;
            end
            S_MULY: begin
                mul_a = r_dy[31:0];
                mul_b = r_cpm;
            end
            S_MULI: begin
                mul_a = r_row;
                mul_b = 32'(w_eff);
            end
            default: begin
                mul_a = 32'b0;
                mul_b = 32'b0;
            end
        endcase
    end

    // Memory port: loads write at acceptance, path lookups read in the address step
    always_comb begin
        mem_req.wr_en = in_acc && (i_in_word.op == pcsc_pkg::OP_LOAD);
        mem_req.wdata = pcsc_pkg::occ_to_cost(i_in_word.occupancy);
        if (r_state == S_ADDR) begin
            mem_req.addr = mul_prod[pcsc_pkg::STORE_AW-1:0] + r_col[pcsc_pkg::STORE_AW-1:0];
        end else begin
            mem_req.addr = i_in_word.cell_index;
        end
    end

    pcsc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    pcsc_cost_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (cost)
    );

    assign emit = (r_state == S_DONE) && r_last && out_free;

    // Sequence one word
    always_comb begin
        n_state     = r_state;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_col       = r_col;
        n_row       = r_row;
        n_last      = r_last;
        n_map_ready = r_map_ready;
        n_stopped   = r_stopped;
        n_verdict   = r_verdict;
        n_run_max   = r_run_max;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.op)
                        pcsc_pkg::OP_COMMIT: begin
                            n_map_ready = 1'b1;
                        end
                        pcsc_pkg::OP_PATH: begin
                            n_last  = i_in_word.last;
                            n_dx    = {i_in_word.pos_x[31], i_in_word.pos_x}
                                      - {r_origin_x[31], r_origin_x};
                            n_dy    = {i_in_word.pos_y[31], i_in_word.pos_y}
                                      - {r_origin_y[31], r_origin_y};
                            n_state = S_DONE;
                            if (!r_stopped) begin
                                if (!r_check_enable) begin
                                    n_stopped = 1'b1;
                                    n_verdict = pcsc_pkg::REASON_DISABLED;
                                end else if (!r_map_ready) begin
                                    n_stopped = 1'b1;
                                    n_verdict = pcsc_pkg::REASON_NO_MAP;
                                end else begin
                                    n_state = S_MULX;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MULX: begin
                n_state = S_MULY;
            end
            S_MULY: begin
                n_col   = prod_hi;
                n_state = S_RANGE;
            end
            S_RANGE: begin
                n_row = prod_hi;
                if (off_map) begin
                    n_stopped = 1'b1;
                    n_verdict = pcsc_pkg::REASON_OUT;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_MULI;
                end
            end
            S_MULI: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (cost > r_run_max) begin
                    n_run_max = cost;
                end
                if (cost == pcsc_pkg::COST_UNKNOWN) begin
                    if (!r_allow_unknown) begin
                        n_stopped = 1'b1;
                        n_verdict = pcsc_pkg::REASON_UNKNOWN;
                    end
                end else if (cost >= r_threshold) begin
                    n_stopped = 1'b1;
                    n_verdict = pcsc_pkg::REASON_HIGH;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_word.reason    = r_verdict;
                    n_out_word.safe      = (r_verdict <= pcsc_pkg::REASON_DISABLED);
                    n_out_word.peak_cost = r_run_max;
                    n_stopped            = 1'b0;
                    n_verdict            = pcsc_pkg::REASON_SAFE;
                    n_run_max            = 8'd0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_ready <= 1'b0;
            r_stopped   <= 1'b0;
            r_verdict   <= pcsc_pkg::REASON_SAFE;
            r_run_max   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map_ready <= n_map_ready;
            r_stopped   <= n_stopped;
            r_verdict   <= n_verdict;
            r_run_max   <= n_run_max;
            r_out_valid <= n_out_valid;
        end
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_col      <= n_col;
        r_row      <= n_row;
        r_last     <= n_last;
        r_out_word <= n_out_word;
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable  <= 1'b1;
            r_allow_unknown <= 1'b0;
            r_threshold     <= pcsc_pkg::THRESHOLD_RST;
            r_map_width     <= pcsc_pkg::MAP_DIM_RST;
            r_map_height    <= pcsc_pkg::MAP_DIM_RST;
            r_origin_x      <= 32'sd0;
            r_origin_y      <= 32'sd0;
            r_cpm           <= pcsc_pkg::CPM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pcsc_pkg::CFG_CHECK_ENABLE:  r_check_enable  <= i_cfg_data[0];
                pcsc_pkg::CFG_ALLOW_UNKNOWN: r_allow_unknown <= i_cfg_data[0];
                pcsc_pkg::CFG_THRESHOLD:     r_threshold     <= i_cfg_data[7:0];
                pcsc_pkg::CFG_MAP_WIDTH:     r_map_width     <= i_cfg_data[8:0];
                pcsc_pkg::CFG_MAP_HEIGHT:    r_map_height    <= i_cfg_data[8:0];
                pcsc_pkg::CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data;
                pcsc_pkg::CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data;
                pcsc_pkg::CFG_CELLS_PER_M:   r_cpm           <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    a_safe_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.safe == (o_out_word.reason <= pcsc_pkg::REASON_DISABLED)))
        else $error("safe flag disagrees with reason");

    a_emit_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (!r_stopped && r_run_max == 8'd0 && r_verdict == pcsc_pkg::REASON_SAFE))
        else $error("path state not cleared after result");

    a_stop_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_verdict != pcsc_pkg::REASON_SAFE))
        else $error("stopped path carries safe verdict");

    a_lookup_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_col < 32'(w_eff) && r_row < 32'(h_eff)))
        else $error("lookup outside the grid");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcsc_pkg::*;

    typedef longint unsigned u64_t;

    // Op code 3 carries no meaning; the block drops such words
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int PHASES      = 10;
    localparam int PER_PHASE   = 133;
    localparam int SETTLE_CYC  = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        t_in_word  w;
        bit        known;
        t_out_word res;
    } step_row_t;

    logic        i_clk;
    logic        rst_n;
    logic        in_valid;
    logic        o_in_stall;
    t_in_word    in_word;
    logic        o_out_valid;
    logic        out_stall;
    t_out_word   o_out_word;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    // Shadow of the block: register copies, cost grid and path state
    logic              chk_en;
    logic              pass_unknown;
    logic [7:0]        thr;
    logic [8:0]        map_w;
    logic [8:0]        map_h;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [31:0]       cpm;
    logic [7:0]        grid_cost [STORE_DEPTH];
    bit                cell_loaded [STORE_DEPTH];
    bit                map_ok;
    bit                path_done;
    logic [2:0]        path_code;
    logic [7:0]        path_peak;

    t_out_word verdict_q [$];
    step_row_t plan [$];
    int        err_cnt;
    int        words_sent;
    int        directed_words;
    int        verdicts_seen;
    bit        no_gaps;

    path_costmap_safety_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int cols();
        return (map_w > 9'(MAX_WIDTH_DEF)) ? MAX_WIDTH_DEF : int'(map_w);
    endfunction

    function automatic int rows();
        return (map_h > 9'(MAX_HEIGHT_DEF)) ? MAX_HEIGHT_DEF : int'(map_h);
    endfunction

    function automatic logic [7:0] occ_cost(logic signed [7:0] occ);
        if (occ < 0) return COST_UNKNOWN;
        if (occ == 0) return 8'd0;
        if (occ > 8'(OCC_FULL)) return COST_LETHAL;
        return 8'((int'(occ) * OCC_SCALE + OCC_HALF) / OCC_FULL);
    endfunction

    // Map one world coordinate to a grid coordinate; zero when off the grid
    function automatic bit axis_cell(logic signed [31:0] pos, logic signed [31:0] org,
                                     int lim, output int pos_idx);
        longint      d;
        logic [65:0] prod;
        pos_idx = 0;
        d = longint'(pos) - longint'(org);
        if (d < 0) return 1'b0;
        prod = 66'(d) * 66'(cpm);
        if (prod[65:32] >= 34'(lim)) return 1'b0;
        pos_idx = int'(prod[65:32]);
        return 1'b1;
    endfunction

    function automatic bit pose_cell(t_in_word w, output int idx);
        int cx;
        int cy;
        idx = 0;
        if (!axis_cell(w.pos_x, org_x, cols(), cx)) return 1'b0;
        if (!axis_cell(w.pos_y, org_y, rows(), cy)) return 1'b0;
        idx = (cy * cols() + cx) & (STORE_DEPTH - 1);
        return 1'b1;
    endfunction

    // Advance the shadow by one word; flag a verdict on the last pose
    function automatic void path_step(t_in_word w, output bit emits, output t_out_word res);
        int         idx;
        logic [7:0] c;
        logic [2:0] why;
        emits = 1'b0;
        res   = '0;
        case (w.op)
            OP_LOAD: begin
                grid_cost[w.cell_index]   = occ_cost(w.occupancy);
                cell_loaded[w.cell_index] = 1'b1;
            end
            OP_COMMIT: map_ok = 1'b1;
            OP_PATH: begin
                if (!path_done) begin
                    why = REASON_SAFE;
                    if (!chk_en) begin
                        why = REASON_DISABLED;
                    end else if (!map_ok) begin
                        why = REASON_NO_MAP;
                    end else if (!pose_cell(w, idx)) begin
                        why = REASON_OUT;
                    end else begin
                        c = grid_cost[idx];
                        if (c > path_peak) path_peak = c;
                        if (c == COST_UNKNOWN) begin
                            if (!pass_unknown) why = REASON_UNKNOWN;
                        end else if (c >= thr) begin
                            why = REASON_HIGH;
                        end
                    end
                    if (why != REASON_SAFE) begin
                        path_done = 1'b1;
                        path_code = why;
                    end
                end
                if (w.last) begin
                    res = '{path_code, (path_code <= REASON_DISABLED), path_peak};
                    emits     = 1'b1;
                    path_done = 1'b0;
                    path_code = REASON_SAFE;
                    path_peak = 8'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // Pick a world coordinate that lands on a random in-range grid coordinate
    function automatic logic [31:0] aim_axis(logic signed [31:0] org, int lim);
        u64_t   lo;
        u64_t   hi;
        u64_t   d;
        longint p;
        int     c;
        if (lim == 0) return $urandom;
        c = $urandom_range(lim - 1, 0);
        if (cpm == 0) begin
            d = u64_t'($urandom_range(4096, 0));
        end else begin
            lo = ((u64_t'(c) << 32) + cpm - 1) / cpm;
            hi = ((u64_t'(c + 1) << 32) + cpm - 1) / cpm - 1;
            d  = lo + u64_t'($urandom) % (hi - lo + 1);
        end
        p = longint'(org) + longint'(d);
        if (p > 64'sh7FFFFFFF) return $urandom;
        return 32'(p);
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.op         = 2'($urandom);
        w.cell_index = 16'($urandom);
        w.occupancy  = 8'($urandom);
        w.pos_x      = $urandom;
        w.pos_y      = $urandom;
        w.last       = 1'($urandom);
        return w;
    endfunction

    function automatic t_in_word load_word();
        t_in_word w;
        w    = rand_word();
        w.op = OP_LOAD;
        if (cols() > 0 && rows() > 0 && $urandom_range(3, 0) != 0)
            w.cell_index = 16'($urandom_range(rows() - 1, 0) * cols()
                               + $urandom_range(cols() - 1, 0));
        if ($urandom_range(1, 0) == 0) w.occupancy = 8'($urandom_range(OCC_FULL, 0));
        return w;
    endfunction

    function automatic t_in_word mk(logic [1:0] op, int idx, int occ, int px, int py, bit last);
        t_in_word w;
        w.op         = op;
        w.cell_index = 16'(idx);
        w.occupancy  = 8'(occ);
        w.pos_x      = px;
        w.pos_y      = py;
        w.last       = last;
        return w;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_in_word w, bit known, t_out_word res);
        step_row_t row;
        row.w     = w;
        row.known = known;
        row.res   = res;
        plan.insert(plan.size(), row);
    endfunction

    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic flag_error(string what);
        err_cnt++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Drive one word, hold it until taken, then queue its verdict if any
    task automatic issue(t_in_word w, bit known, t_out_word typed);
        int        gap;
        bit        emits;
        t_out_word res;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk) in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        path_step(w, emits, res);
        if (emits) verdict_q.insert(verdict_q.size(), known ? typed : res);
        if (w.op != OP_SPARE) words_sent++;
    endtask

    // Load a cell first when this pose would look up one never written
    task automatic issue_pose(t_in_word w);
        t_in_word fill;
        int       idx;
        if (!path_done && chk_en && map_ok && pose_cell(w, idx) && !cell_loaded[idx]) begin
            fill            = load_word();
            fill.cell_index = 16'(idx);
            issue(fill, 1'b0, '0);
        end
        issue(w, 1'b0, '0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_idx   = idx;
        cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_CHECK_ENABLE:  chk_en       = data[0];
            CFG_ALLOW_UNKNOWN: pass_unknown = data[0];
            CFG_THRESHOLD:     thr          = data[7:0];
            CFG_MAP_WIDTH:     map_w        = data[8:0];
            CFG_MAP_HEIGHT:    map_h        = data[8:0];
            CFG_ORIGIN_X:      org_x        = data;
            CFG_ORIGIN_Y:      org_y        = data;
            CFG_CELLS_PER_M:   cpm          = data;
            default: ;
        endcase
        @(negedge i_clk) cfg_valid = 1'b0;
    endtask

    // Drop valid, drain pending verdicts, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk) in_valid = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Output stall: quiet stretches, short blips and the odd long hold
    initial begin
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(9, 0);
            if (mode < 3) begin
                @(negedge i_clk) out_stall = 1'b0;
                repeat ($urandom_range(80, 20)) @(negedge i_clk);
            end else begin
                @(negedge i_clk) out_stall = 1'b1;
                repeat (mode == 9 ? $urandom_range(39, 9) : $urandom_range(2, 0))
                    @(negedge i_clk);
                @(negedge i_clk) out_stall = 1'b0;
                repeat ($urandom_range(3, 0)) @(negedge i_clk);
            end
        end
    end

    // Compare each taken verdict with the oldest one queued
    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_n && o_out_valid && !out_stall) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("verdict %0d arrived with nothing pending", verdicts_seen));
            end else begin
                want = verdict_q.pop_front();
                if (o_out_word.reason !== want.reason)
                    flag_error($sformatf("verdict %0d reason %0d, want %0d",
                                         verdicts_seen, o_out_word.reason, want.reason));
                if (o_out_word.safe !== want.safe)
                    flag_error($sformatf("verdict %0d safe %0b, want %0b",
                                         verdicts_seen, o_out_word.safe, want.safe));
                if (o_out_word.peak_cost !== want.peak_cost)
                    flag_error($sformatf("verdict %0d peak cost %0d, want %0d",
                                         verdicts_seen, o_out_word.peak_cost, want.peak_cost));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d verdicts pending",
                 CYCLE_LIMIT, verdict_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [31:0] setting [8];
        t_in_word    w;
        int          goal;
        int          r;
        int          len;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        err_cnt   = 0;
        words_sent    = 0;
        verdicts_seen = 0;

        chk_en       = 1'b1;
        pass_unknown = 1'b0;
        thr          = THRESHOLD_RST;
        map_w        = MAP_DIM_RST;
        map_h        = MAP_DIM_RST;
        org_x        = '0;
        org_y        = '0;
        cpm          = CPM_RST;
        map_ok       = 1'b0;
        path_done    = 1'b0;
        path_code    = REASON_SAFE;
        path_peak    = 8'd0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) rst_n = 1'b1;

        // Directed words under reset settings: 20 cells per meter, so 3277*k
        // lands in column k; cell 256 is row 1, column 0
        add_row(mk(OP_PATH, 0, 0, 0, 0, 1), 1'b1, '{REASON_NO_MAP, 1'b0, 8'd0});
        add_row(mk(OP_LOAD, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 1, 1, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 2, 50, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 3, 51, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 4, 127, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 5, -1, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 6, -128, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 7, 25, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD, 256, 10, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_SPARE, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk(OP_COMMIT, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_PATH, 0, 0, 0, 0, 1), 1'b1, '{REASON_SAFE, 1'b1, 8'd0});
        add_row(mk(OP_PATH, 0, 0, 3277, 0, 0), 1'b0, '0);
        add_row(mk(OP_PATH, 0, 0, 3277 * 7, 0, 1), 1'b1, '{REASON_SAFE, 1'b1, 8'd126});
        add_row(mk(OP_PATH, 0, 0, 3277 * 2, 0, 1), 1'b1, '{REASON_SAFE, 1'b1, 8'd252});
        add_row(mk(OP_PATH, 0, 0, 3277 * 3, 0, 1), 1'b1, '{REASON_HIGH, 1'b0, 8'd254});
        add_row(mk(OP_PATH, 0, 0, 3277 * 5, 0, 1), 1'b1, '{REASON_UNKNOWN, 1'b0, 8'd255});
        // Unknown cell stops the path; the later lethal pose is ignored
        add_row(mk(OP_PATH, 0, 0, 3277, 0, 0), 1'b0, '0);
        add_row(mk(OP_PATH, 0, 0, 3277 * 6, 0, 0), 1'b0, '0);
        add_row(mk(OP_PATH, 0, 0, 3277 * 4, 0, 1), 1'b1, '{REASON_UNKNOWN, 1'b0, 8'd255});
        add_row(mk(OP_PATH, 0, 0, -1, 0, 1), 1'b1, '{REASON_OUT, 1'b0, 8'd0});
        add_row(mk(OP_PATH, 0, 0, 32'h7FFFFFFF, 0, 1), 1'b1, '{REASON_OUT, 1'b0, 8'd0});
        add_row(mk(OP_PATH, 0, 0, 32'h80000000, 32'h80000000, 1), 1'b1,
                '{REASON_OUT, 1'b0, 8'd0});
        add_row(mk(OP_PATH, 0, 0, 0, 3277, 1), 1'b1, '{REASON_SAFE, 1'b1, 8'd50});

        foreach (plan[i]) issue(plan[i].w, plan[i].known, plan[i].res);
        directed_words = words_sent;

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            setting[CFG_CHECK_ENABLE]  = ($urandom_range(7, 0) != 0);
            setting[CFG_ALLOW_UNKNOWN] = $urandom_range(1, 0);
            setting[CFG_THRESHOLD]     = $urandom_range(255, 1);
            setting[CFG_MAP_WIDTH]     = $urandom_range(24, 1);
            setting[CFG_MAP_HEIGHT]    = $urandom_range(24, 1);
            setting[CFG_ORIGIN_X]      = 32'($urandom_range(1 << 20, 0)) - 32'(1 << 19);
            setting[CFG_ORIGIN_Y]      = 32'($urandom_range(1 << 20, 0)) - 32'(1 << 19);
            setting[CFG_CELLS_PER_M]   = $urandom_range(4 * CPM_RST, 1 << 14);
            case (ph)
                0: begin
                    // Explicit reset values over the full grid
                    setting[CFG_CHECK_ENABLE]  = 32'd1;
                    setting[CFG_ALLOW_UNKNOWN] = 32'd0;
                    setting[CFG_THRESHOLD]     = 32'(THRESHOLD_RST);
                    setting[CFG_MAP_WIDTH]     = 32'(MAP_DIM_RST);
                    setting[CFG_MAP_HEIGHT]    = 32'(MAP_DIM_RST);
                    setting[CFG_ORIGIN_X]      = 32'd0;
                    setting[CFG_ORIGIN_Y]      = 32'd0;
                    setting[CFG_CELLS_PER_M]   = CPM_RST;
                end
                1: begin
                    // Single cell, extreme origins, densest grid
                    setting[CFG_CHECK_ENABLE]  = 32'd1;
                    setting[CFG_ALLOW_UNKNOWN] = 32'd1;
                    setting[CFG_THRESHOLD]     = 32'd255;
                    setting[CFG_MAP_WIDTH]     = 32'd1;
                    setting[CFG_MAP_HEIGHT]    = 32'd1;
                    setting[CFG_ORIGIN_X]      = 32'h80000000;
                    setting[CFG_ORIGIN_Y]      = 32'h7FFFFFFF;
                    setting[CFG_CELLS_PER_M]   = 32'hFFFFFFFF;
                end
                2: setting[CFG_CHECK_ENABLE] = 32'd0;
                3: begin
                    // Zero threshold, oversized width, coarsest grid
                    setting[CFG_CHECK_ENABLE] = 32'd1;
                    setting[CFG_THRESHOLD]    = 32'd0;
                    setting[CFG_MAP_WIDTH]    = 32'd511;
                    setting[CFG_MAP_HEIGHT]   = 32'd300;
                    setting[CFG_CELLS_PER_M]  = 32'd1;
                end
                4: begin
                    setting[CFG_CHECK_ENABLE] = 32'd1;
                    setting[CFG_MAP_WIDTH]    = 32'd0;
                end
                5: begin
                    setting[CFG_CHECK_ENABLE] = 32'd1;
                    setting[CFG_MAP_HEIGHT]   = 32'd0;
                end
                6: begin
                    setting[CFG_CHECK_ENABLE]  = 32'd1;
                    setting[CFG_ALLOW_UNKNOWN] = 32'd1;
                    setting[CFG_CELLS_PER_M]   = 32'd0;
                end
                7: begin
                    setting[CFG_ORIGIN_X]    = $urandom;
                    setting[CFG_ORIGIN_Y]    = $urandom;
                    setting[CFG_CELLS_PER_M] = $urandom;
                end
                default: ;
            endcase
            for (int k = 0; k < 8; k++) write_reg(3'(k), setting[k]);
            no_gaps = (ph % 4 == 1);
            goal    = words_sent + PER_PHASE;

            // Seed the map, then commit it
            repeat ($urandom_range(30, 10)) issue(load_word(), 1'b0, '0);
            w    = rand_word();
            w.op = OP_COMMIT;
            issue(w, 1'b0, '0);

            while (words_sent < goal) begin
                r = $urandom_range(99, 0);
                if (r < 70) begin
                    // Well-formed path, mostly on the grid
                    len = $urandom_range(6, 1);
                    for (int j = 0; j < len; j++) begin
                        w      = rand_word();
                        w.op   = OP_PATH;
                        w.last = (j == len - 1);
                        r      = $urandom_range(99, 0);
                        if (r < 85) begin
                            w.pos_x = aim_axis(org_x, cols());
                            w.pos_y = aim_axis(org_y, rows());
                        end else if (r < 95) begin
                            w.pos_y = aim_axis(org_y, rows());
                            w.pos_x = org_x - 32'sd1;
                        end
                        issue_pose(w);
                    end
                end else if (r < 85) begin
                    issue(load_word(), 1'b0, '0);
                end else if (r < 90) begin
                    w    = rand_word();
                    w.op = OP_COMMIT;
                    issue(w, 1'b0, '0);
                end else if (r < 95) begin
                    w    = rand_word();
                    w.op = OP_SPARE;
                    issue(w, 1'b0, '0);
                end else begin
                    w    = rand_word();
                    w.op = OP_PATH;
                    issue_pose(w);
                end
            end

            // Close any open path before the next register change
            w       = rand_word();
            w.op    = OP_PATH;
            w.last  = 1'b1;
            w.pos_x = aim_axis(org_x, cols());
            w.pos_y = aim_axis(org_y, rows());
            issue_pose(w);
        end

        settle();
        $display("Drove %0d words (%0d directed) across %0d register settings.",
                 words_sent, directed_words, PHASES);
        $display("Checked %0d path verdicts, %0d mismatches.", verdicts_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pcsc_pkg.sv
rtl/pcsc_cost_mem.sv
rtl/pcsc_mul.sv
rtl/path_costmap_safety_check.sv
tb/sv/tb_top.sv
